// ===== hdl/text_terminal_cell_writer_macros.svh =====
// Assertion macros used by the text terminal cell writer RTL (ttcw_engine).
// The macros expect signals named clk and rst_n in the including module.
`ifndef TEXT_TERMINAL_CELL_WRITER_MACROS_SVH
`define TEXT_TERMINAL_CELL_WRITER_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define TTCW_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define TTCW_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define TTCW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ttcw_pkg.sv =====
// Package for the text terminal cell writer: payload types, codes and defaults.
// No dependencies; ttcw_regs, ttcw_engine, the top level and the testbench import it.
package ttcw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam int KIND_W  = 2;
    localparam int CHAR_W  = 8;
    localparam int ATTR_W  = 8;
    localparam int IDX_W   = 11;
    localparam int WORD_W  = ATTR_W + CHAR_W;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'd7;

    // Register index of the attribute register on the configuration port.
    localparam logic REG_TEXT_ATTRIBUTE = 1'b0;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CHAR_W-1:0] char_code;
        logic [IDX_W-1:0]  cell_index;
    } cmd_item_t;

    typedef struct packed {
        logic [WORD_W-1:0] cell_word;
        logic [IDX_W-1:0]  cursor_index;
    } rsp_item_t;

endpackage

// ===== hdl/ttcw_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No package dependencies.
module ttcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/ttcw_regs.sv =====
// APB-style configuration port holding the text attribute register.
// Depends on ttcw_pkg for widths, the register index and the reset value.
module ttcw_regs
    import ttcw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [ATTR_W-1:0]  text_attribute
);

    logic [ATTR_W-1:0] attr_reg;
    logic [ATTR_W-1:0] attr_next;
    logic              hit;

    // Registers sit on word boundaries, so bit 2 upward selects the register.
    assign hit    = (paddr[PADDR_W-1:2] == {(PADDR_W-2){REG_TEXT_ATTRIBUTE}});
    assign pready = 1'b1;

    always_comb
    begin
        attr_next = attr_reg;
        if (psel && penable && pwrite && pready && hit)
        begin
            attr_next = pwdata[ATTR_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (hit)
        begin
            prdata = PDATA_W'(attr_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= RESET_ATTR;
        end
        else
        begin
            attr_reg <= attr_next;
        end
    end

    assign text_attribute = attr_reg;

endmodule

// ===== hdl/ttcw_engine.sv =====
// Terminal sequencer: cursor, screen store accesses, clearing sweep and result queue.
// Depends on ttcw_pkg and on text_terminal_cell_writer_macros.svh for assertions.
`include "text_terminal_cell_writer_macros.svh"

module ttcw_engine
    import ttcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cmd_valid,
    output logic                             cmd_ready,
    input  cmd_item_t                        cmd,
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output rsp_item_t                        rsp,
    input  logic [ATTR_W-1:0]                text_attribute,
    output logic                             mem_we,
    output logic [$clog2(ROWS*COLUMNS)-1:0]  mem_waddr,
    output logic [WORD_W-1:0]                mem_wdata,
    output logic [$clog2(ROWS*COLUMNS)-1:0]  mem_raddr,
    input  logic [WORD_W-1:0]                mem_rdata
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_READ  = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     col_reg, col_next;
    logic [RW-1:0]     row_reg, row_next;
    logic [AW-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [ATTR_W-1:0] clr_attr_reg, clr_attr_next;
    logic              rd_ok_reg, rd_ok_next;

    rsp_item_t         out_reg, out_next;
    rsp_item_t         skid_reg, skid_next;
    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;

    logic              accept;
    logic              pop;
    logic              push;
    logic [WORD_W-1:0] push_word;
    logic              go_next_row;
    logic [CW:0]       col_inc;
    logic [RW:0]       row_inc;
    logic              at_row_end;
    logic              last_row;
    logic [CW-1:0]     col_bs;
    logic [CW-1:0]     wr_col;
    logic [AW-1:0]     wr_pos;
    logic [AW-1:0]     pos_next;
    logic [IDX_W+AW-1:0] idx_ext;
    logic [IDX_W+AW-1:0] pos_ext;
    logic              idx_in_range;

    assign cmd_ready = (state_reg == ST_IDLE) && !skid_valid_reg;
    assign accept    = cmd_valid && cmd_ready;
    assign pop       = out_valid_reg && rsp_ready;

    assign col_inc    = {1'b0, col_reg} + 1'b1;
    assign row_inc    = {1'b0, row_reg} + 1'b1;
    assign at_row_end = (col_inc == (CW+1)'(COLUMNS));
    assign last_row   = (row_inc == (RW+1)'(ROWS));
    assign col_bs     = (col_reg != '0) ? col_reg - 1'b1 : col_reg;
    assign wr_col     = (cmd.char_code == CH_BACKSPACE) ? col_bs : col_reg;
    assign wr_pos     = AW'(row_reg) * AW'(COLUMNS) + AW'(wr_col);
    assign pos_next   = AW'(row_next) * AW'(COLUMNS) + AW'(col_next);

    assign idx_ext      = (IDX_W+AW)'(cmd.cell_index);
    assign idx_in_range = (idx_ext < (IDX_W+AW)'(CELLS));
    assign pos_ext      = (IDX_W+AW)'(pos_next);
    assign mem_raddr    = idx_ext[AW-1:0];

    always_comb
    begin
        state_next    = state_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        clr_cnt_next  = clr_cnt_reg;
        clr_attr_next = clr_attr_reg;
        rd_ok_next    = rd_ok_reg;
        mem_we        = 1'b0;
        mem_waddr     = wr_pos;
        mem_wdata     = {text_attribute, cmd.char_code};
        push          = 1'b0;
        push_word     = '0;
        go_next_row   = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = {clr_attr_reg, CH_SPACE};
                if (clr_cnt_reg == AW'(CELLS - 1))
                begin
                    clr_cnt_next = '0;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.kind)
                        KIND_PUT:
                        begin
                            push = 1'b1;
                            if (cmd.char_code == CH_NEWLINE)
                            begin
                                go_next_row = 1'b1;
                            end
                            else if (cmd.char_code == CH_BACKSPACE)
                            begin
                                col_next  = col_bs;
                                mem_we    = 1'b1;
                                mem_wdata = {text_attribute, CH_SPACE};
                            end
                            else
                            begin
                                mem_we = 1'b1;
                                if (at_row_end)
                                begin
                                    go_next_row = 1'b1;
                                end
                                else
                                begin
                                    col_next = col_inc[CW-1:0];
                                end
                            end
                            // Running off the last row homes the cursor and blanks
                            // the screen with the attribute in force now.
                            if (go_next_row)
                            begin
                                col_next = '0;
                                if (last_row)
                                begin
                                    row_next      = '0;
                                    clr_attr_next = text_attribute;
                                    state_next    = ST_CLEAR;
                                end
                                else
                                begin
                                    row_next = row_inc[RW-1:0];
                                end
                            end
                        end
                        KIND_READ:
                        begin
                            rd_ok_next = idx_in_range;
                            state_next = ST_READ;
                        end
                        KIND_CLEAR:
                        begin
                            push          = 1'b1;
                            col_next      = '0;
                            row_next      = '0;
                            clr_attr_next = text_attribute;
                            state_next    = ST_CLEAR;
                        end
                        default:
                        begin
                            push = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                push       = 1'b1;
                push_word  = rd_ok_reg ? mem_rdata : '0;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Two-entry result queue; the skid entry fills only while the head stalls.
    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (pop)
        begin
            out_next        = skid_reg;
            out_valid_next  = skid_valid_reg;
            skid_valid_next = 1'b0;
        end
        if (push)
        begin
            if (!out_valid_next)
            begin
                out_valid_next         = 1'b1;
                out_next.cell_word     = push_word;
                out_next.cursor_index  = pos_ext[IDX_W-1:0];
            end
            else
            begin
                skid_valid_next        = 1'b1;
                skid_next.cell_word    = push_word;
                skid_next.cursor_index = pos_ext[IDX_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            col_reg        <= '0;
            row_reg        <= '0;
            clr_cnt_reg    <= '0;
            clr_attr_reg   <= RESET_ATTR;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            clr_cnt_reg    <= clr_cnt_next;
            clr_attr_reg   <= clr_attr_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ok_reg <= rd_ok_next;
        out_reg   <= out_next;
        skid_reg  <= skid_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    `TTCW_ASSERT_IMP(a_queue_no_overflow, push, !(skid_valid_reg && !pop), "result queue overflow")
    `TTCW_ASSERT_ALWAYS(a_cursor_in_range, ({1'b0, col_reg} < (CW+1)'(COLUMNS)) && ({1'b0, row_reg} < (RW+1)'(ROWS)), "cursor outside the screen")
    `TTCW_ASSERT_IMP(a_home_while_clearing, state_reg == ST_CLEAR, (col_reg == '0) && (row_reg == '0), "cursor not home during clear sweep")
    `TTCW_ASSERT_NEXT(a_read_returns, accept && (cmd.kind == KIND_READ), push && (state_reg == ST_READ), "read produced no result")

endmodule

// ===== hdl/text_terminal_cell_writer.sv =====
// Top level of the text terminal cell writer: configuration port, sequencer and screen RAM.
// Depends on ttcw_pkg, ttcw_regs, ttcw_engine and ttcw_ram.
//
// Character-cell terminal with a ROWS x COLUMNS screen of 16-bit cells (attribute
// byte high, character byte low) kept in one synchronous RAM. Every command transfer
// yields exactly one response transfer carrying the cursor position after the
// command. A put, a clear or an unused kind queues its response in the cycle it is
// taken; a read queues its response in the cycle after, from the read state, since the
// screen RAM registers its read data. A clear, and a put that runs past the last row,
// then sweeps blanks into all ROWS*COLUMNS cells (2000 at 80x25) through the RAM's
// single write port before the next command is taken. After reset the same sweep fills
// the screen with spaces in attribute 7, and no command is taken until it ends; the
// attribute register can be written at any time. Two response entries are buffered,
// so a command is taken while a finished response still waits.
module text_terminal_cell_writer
    import ttcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  cmd_item_t          cmd,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output rsp_item_t          rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);

    logic [ATTR_W-1:0] text_attribute;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [WORD_W-1:0] mem_rdata;

    ttcw_regs u_regs (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .text_attribute (text_attribute)
    );

    ttcw_engine #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_engine (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd_ready      (cmd_ready),
        .cmd            (cmd),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .rsp            (rsp),
        .text_attribute (text_attribute),
        .mem_we         (mem_we),
        .mem_waddr      (mem_waddr),
        .mem_wdata      (mem_wdata),
        .mem_raddr      (mem_raddr),
        .mem_rdata      (mem_rdata)
    );

    ttcw_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CELLS)
    ) u_screen (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for text_terminal_cell_writer: directed and random command
// traffic, checked against a behavioral screen and cursor model. Depends on ttcw_pkg.
module tb;
    import ttcw_pkg::*;

    localparam int COLUMNS      = DEF_COLUMNS;
    localparam int ROWS         = DEF_ROWS;
    localparam int CELLS        = COLUMNS * ROWS;
    localparam int SWEEP_CYCLES = CELLS + 16;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cmd_valid = 1'b0;
    logic               cmd_ready;
    cmd_item_t          cmd = '0;
    logic               rsp_valid;
    logic               rsp_ready = 1'b0;
    rsp_item_t          rsp;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // Behavioral copy of the terminal: screen contents, cursor and attribute.
    logic [WORD_W-1:0] screen_cells [CELLS];
    int                cur_col;
    int                cur_row;
    logic [ATTR_W-1:0] text_attr;

    rsp_item_t awaited_rsp [$];
    bit        mismatch_seen = 1'b0;
    int        cmd_idle_pct = 0;
    int        rsp_stall_pct = 0;
    int        cmds_sent = 0;

    text_terminal_cell_writer #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd      (cmd),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 clk = ~clk;

    initial
    begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic void blank_screen();
        for (int i = 0; i < CELLS; i++)
        begin
            screen_cells[i] = {text_attr, CH_SPACE};
        end
        cur_col = 0;
        cur_row = 0;
    endfunction

    function automatic void advance_row();
        cur_col = 0;
        cur_row++;
        if (cur_row >= ROWS)
        begin
            blank_screen();
        end
    endfunction

    function automatic int cursor_pos();
        return cur_row * COLUMNS + cur_col;
    endfunction

    function automatic rsp_item_t apply_command(cmd_item_t c);
        rsp_item_t r;
        r = '0;
        case (c.kind)
            KIND_PUT:
            begin
                if (c.char_code == CH_NEWLINE)
                begin
                    advance_row();
                end
                else if (c.char_code == CH_BACKSPACE)
                begin
                    if (cur_col > 0)
                    begin
                        cur_col--;
                    end
                    screen_cells[cursor_pos()] = {text_attr, CH_SPACE};
                end
                else
                begin
                    screen_cells[cursor_pos()] = {text_attr, c.char_code};
                    cur_col++;
                    if (cur_col >= COLUMNS)
                    begin
                        advance_row();
                    end
                end
            end
            KIND_READ:
            begin
                if (c.cell_index < CELLS)
                begin
                    r.cell_word = screen_cells[c.cell_index];
                end
            end
            KIND_CLEAR:
            begin
                blank_screen();
            end
            default:
            begin
            end
        endcase
        r.cursor_index = IDX_W'(cursor_pos());
        return r;
    endfunction

    function automatic cmd_item_t make_cmd(logic [KIND_W-1:0] kind, logic [CHAR_W-1:0] ch,
                                           logic [IDX_W-1:0] idx);
        cmd_item_t c;
        c.kind = kind;
        c.char_code = ch;
        c.cell_index = idx;
        return c;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    // Valid is left high so that back-to-back commands keep it asserted.
    task automatic send_cmd(cmd_item_t c);
        while ($urandom_range(99) < cmd_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= c;
        do
            @(posedge clk);
        while (!cmd_ready);
        awaited_rsp.push_back(apply_command(c));
        cmds_sent++;
        @(negedge clk);
    endtask

    task automatic wait_for_drain();
        cmd_valid <= 1'b0;
        while (awaited_rsp.size() != 0)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // A clear can still be sweeping after its response, so the attribute is only
    // changed once that sweep has had time to finish.
    task automatic set_attribute(logic [ATTR_W-1:0] value);
        wait_for_drain();
        repeat (SWEEP_CYCLES) @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'({REG_TEXT_ATTRIBUTE, 2'b00});
        pwdata <= PDATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        text_attr = value;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    always @(negedge clk)
    begin
        rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
    end

    always @(posedge clk)
    begin
        rsp_item_t exp_rsp;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (awaited_rsp.size() == 0)
            begin
                $error("Response transfer with no command outstanding: %h", rsp);
                mismatch_seen = 1'b1;
            end
            else
            begin
                exp_rsp = awaited_rsp.pop_front();
                if (rsp.cell_word !== exp_rsp.cell_word)
                begin
                    $error("cell_word: expected %h, got %h", exp_rsp.cell_word, rsp.cell_word);
                    mismatch_seen = 1'b1;
                end
                if (rsp.cursor_index !== exp_rsp.cursor_index)
                begin
                    $error("cursor_index: expected %0d, got %0d", exp_rsp.cursor_index,
                           rsp.cursor_index);
                    mismatch_seen = 1'b1;
                end
            end
        end
    end

    task automatic test_reset_state();
        send_cmd(make_cmd(KIND_READ, 8'h00, 11'd0));
        send_cmd(make_cmd(KIND_READ, 8'hFF, IDX_W'(CELLS - 1)));
        send_cmd(make_cmd(KIND_READ, 8'h00, IDX_W'(CELLS)));
        send_cmd(make_cmd(KIND_READ, 8'hFF, 11'h7FF));
        send_cmd(make_cmd(KIND_UNUSED, 8'hFF, 11'h7FF));
    endtask

    task automatic test_put_edges();
        send_cmd(make_cmd(KIND_PUT, 8'h00, 11'h7FF));
        send_cmd(make_cmd(KIND_PUT, 8'hFF, 11'h000));
        send_cmd(make_cmd(KIND_PUT, 8'h41, 11'h555));
        send_cmd(make_cmd(KIND_READ, 8'h00, 11'd0));
        send_cmd(make_cmd(KIND_READ, 8'h00, 11'd1));
        send_cmd(make_cmd(KIND_READ, 8'h00, 11'd2));
        send_cmd(make_cmd(KIND_PUT, CH_NEWLINE, 11'h2AA));
        send_cmd(make_cmd(KIND_PUT, 8'h7E, 11'd0));
        send_cmd(make_cmd(KIND_CLEAR, 8'hFF, 11'h7FF));
        send_cmd(make_cmd(KIND_READ, 8'h00, IDX_W'(COLUMNS)));
        // The sender holds off here until the block has answered everything.
        wait_for_drain();
    endtask

    task automatic test_backspace();
        send_cmd(make_cmd(KIND_PUT, 8'h51, 11'd0));
        send_cmd(make_cmd(KIND_PUT, CH_BACKSPACE, 11'd0));
        send_cmd(make_cmd(KIND_PUT, CH_BACKSPACE, 11'd0));
        send_cmd(make_cmd(KIND_READ, 8'h00, 11'd0));
        send_cmd(make_cmd(KIND_PUT, CH_NEWLINE, 11'd0));
        send_cmd(make_cmd(KIND_PUT, CH_BACKSPACE, 11'd0));
        send_cmd(make_cmd(KIND_READ, 8'h00, IDX_W'(COLUMNS)));
    endtask

    // Mostly lines of text and newline runs, so that rows wrap and the screen
    // scrolls off the bottom, mixed with reads, clears and unconstrained noise.
    task automatic test_random_traffic(int item_count, int idle_pct, int stall_pct,
                                       logic [ATTR_W-1:0] attr);
        int                stop_at;
        int                sel;
        int                len;
        int                pos;
        logic [CHAR_W-1:0] ch;
        cmd_item_t         c;
        set_attribute(attr);
        cmd_idle_pct = idle_pct;
        rsp_stall_pct = stall_pct;
        stop_at = cmds_sent + item_count;
        while (cmds_sent < stop_at)
        begin
            sel = $urandom_range(99);
            if (sel < 40)
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(60, 100) : $urandom_range(1, 30);
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(19) == 0)
                    begin
                        ch = CH_BACKSPACE;
                    end
                    else if ($urandom_range(9) == 0)
                    begin
                        ch = CHAR_W'($urandom);
                    end
                    else
                    begin
                        ch = CHAR_W'($urandom_range(32, 126));
                    end
                    send_cmd(make_cmd(KIND_PUT, ch, IDX_W'($urandom)));
                end
                if ($urandom_range(9) < 7)
                begin
                    send_cmd(make_cmd(KIND_PUT, CH_NEWLINE, IDX_W'($urandom)));
                end
            end
            else if (sel < 48)
            begin
                len = $urandom_range(1, 30);
                for (int i = 0; i < len; i++)
                begin
                    send_cmd(make_cmd(KIND_PUT, CH_NEWLINE, IDX_W'($urandom)));
                end
            end
            else if (sel < 75)
            begin
                sel = $urandom_range(9);
                if (sel < 5)
                begin
                    pos = (cursor_pos() > 0) ? cursor_pos() - $urandom_range(1, cursor_pos() < 4 ?
                                                                           cursor_pos() : 4) : 0;
                end
                else if (sel < 9)
                begin
                    pos = $urandom_range(CELLS - 1);
                end
                else
                begin
                    pos = $urandom_range(2047);
                end
                send_cmd(make_cmd(KIND_READ, CHAR_W'($urandom), IDX_W'(pos)));
            end
            else if (sel < 77)
            begin
                send_cmd(make_cmd(KIND_CLEAR, CHAR_W'($urandom), IDX_W'($urandom)));
            end
            else if (sel < 80)
            begin
                send_cmd(make_cmd(KIND_UNUSED, CHAR_W'($urandom), IDX_W'($urandom)));
            end
            else
            begin
                c = cmd_item_t'($urandom);
                send_cmd(c);
            end
            if ($urandom_range(49) == 0)
            begin
                wait_for_drain();
            end
        end
    endtask

    initial
    begin
        text_attr = RESET_ATTR;
        blank_screen();
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_state();
        set_attribute(8'hFF);
        test_put_edges();
        set_attribute(8'h00);
        test_backspace();

        test_random_traffic(175, 0, 0, 8'hFF);
        test_random_traffic(175, 45, 0, 8'h00);
        test_random_traffic(175, 0, 45, CHAR_W'($urandom));
        test_random_traffic(175, 12, 12, 8'h5A);

        cmd_valid <= 1'b0;
        while (awaited_rsp.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SWEEP_CYCLES) @(posedge clk);
        @(negedge clk);
        if (!mismatch_seen)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/ttcw_pkg.sv
hdl/ttcw_ram.sv
hdl/ttcw_regs.sv
hdl/ttcw_engine.sv
hdl/text_terminal_cell_writer.sv
tb/tb.sv
